>>> src/sads_pkg.sv
// Package for the shared-array dual stack.
// Holds operation and status codes, sequencer states and the memory control struct.
// Used by every module under src; it depends on nothing.
package sads_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Configuration port geometry: one register at byte address 0.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes carried by an input transfer.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_HOLD
  } state_t;

  // Memory port controls from the sequencer.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> src/sads_mem.sv
// Single-port entry memory for the dual stack.
// One write or one registered read per cycle; uses sads_pkg for the control struct.
module sads_mem
  import sads_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  mem_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] store_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port and registered read port share the address.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store_r[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= store_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/sads_seq.sv
// Sequencer, stack pointers, shared compare unit and output register of the dual stack.
// Drives the entry memory in sads_mem; uses sads_pkg for codes and states.
module sads_seq
  import sads_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Effective capacity and the clear pulse of a capacity write
  input  logic [$clog2(DEPTH+1)-1:0] cap_eff,
  input  logic                       cfg_clear,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic                       in_side,
  input  logic [DATA_WIDTH-1:0]      in_value,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [DATA_WIDTH-1:0]      out_data,
  output logic [$clog2(DEPTH)-1:0]   out_found_index,
  output logic [$clog2(DEPTH+1)-1:0] out_count,
  // Memory port
  output mem_ctl_t                   mem_ctl,
  output logic [$clog2(DEPTH)-1:0]   mem_addr,
  output logic [DATA_WIDTH-1:0]      mem_wr_data,
  input  logic [DATA_WIDTH-1:0]      mem_rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  state_t                state_r, state_nxt;
  logic [2:0]            op_r;
  logic                  side_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]      low_r, low_nxt;
  logic [CNT_W-1:0]      high_r, high_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  status_t               hst_r, hst_nxt;
  logic [DATA_WIDTH-1:0] hdata_r, hdata_nxt;
  logic [IDX_W-1:0]      hfidx_r, hfidx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [IDX_W-1:0]      out_fidx_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [CNT_W-1:0]      n_side;
  logic [CNT_W-1:0]      total;
  logic                  full;
  logic [CNT_W-1:0]      top_c;
  logic [CNT_W-1:0]      push_c;
  logic [IDX_W-1:0]      scan_next;
  logic                  match;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_HOLD) && out_free);
  assign accept   = in_valid && in_ready;

  // Pointer arithmetic for the named side.
  assign n_side    = side_r ? high_r : low_r;
  assign total     = low_r + high_r;
  assign full      = total >= cap_eff;
  assign top_c     = side_r ? (cap_eff - high_r) : (low_r - CNT_W'(1));
  assign push_c    = side_r ? (cap_eff - CNT_W'(1) - high_r) : low_r;
  assign scan_next = side_r ? (idx_r + IDX_W'(1)) : (idx_r - IDX_W'(1));

  // The one shared compare unit: the entry read last cycle against the key.
  assign match = (mem_rd_data == val_r);

  // Next state, memory controls and result capture.
  always_comb begin
    state_nxt   = state_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    idx_nxt     = idx_r;
    left_nxt    = left_r;
    hst_nxt     = hst_r;
    hdata_nxt   = hdata_r;
    hfidx_nxt   = hfidx_r;
    mem_ctl     = '0;
    mem_addr    = top_c[IDX_W-1:0];
    mem_wr_data = val_r;
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        hst_nxt   = ST_OK;
        hdata_nxt = '0;
        hfidx_nxt = '0;
        state_nxt = S_HOLD;
        unique case (op_r) inside
          OP_PUSH: begin
            if (full) begin
              hst_nxt = ST_FULL;
            end else begin
              mem_ctl.wr_en = 1'b1;
              mem_addr      = push_c[IDX_W-1:0];
              if (side_r) begin
                high_nxt = high_r + CNT_W'(1);
              end else begin
                low_nxt = low_r + CNT_W'(1);
              end
            end
          end
          OP_POP, OP_PEEK: begin
            if (n_side == '0) begin
              hst_nxt = ST_EMPTY;
            end else begin
              mem_ctl.rd_en = 1'b1;
              state_nxt     = S_RDWAIT;
              if (op_r == OP_POP) begin
                if (side_r) begin
                  high_nxt = high_r - CNT_W'(1);
                end else begin
                  low_nxt = low_r - CNT_W'(1);
                end
              end
            end
          end
          OP_CLEAR: begin
            if (side_r) begin
              high_nxt = '0;
            end else begin
              low_nxt = '0;
            end
          end
          OP_SEARCH: begin
            if (n_side == '0) begin
              hst_nxt = ST_NOTFOUND;
            end else begin
              mem_ctl.rd_en = 1'b1;
              idx_nxt       = top_c[IDX_W-1:0];
              left_nxt      = n_side;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            // Unused codes change nothing and report ok.
          end
        endcase
      end
      S_RDWAIT: begin
        hdata_nxt = mem_rd_data;
        state_nxt = S_HOLD;
      end
      S_SCAN: begin
        if (match) begin
          hfidx_nxt = idx_r;
          state_nxt = S_HOLD;
        end else if (left_r == CNT_W'(1)) begin
          hst_nxt   = ST_NOTFOUND;
          state_nxt = S_HOLD;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = scan_next;
          idx_nxt       = scan_next;
          left_nxt      = left_r - CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A capacity write empties both stacks.
    if (cfg_clear) begin
      low_nxt  = '0;
      high_nxt = '0;
    end
  end

  // Output valid follows loads and receiver transfers.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: the accepted item, scan position, held and shown results.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      side_r <= in_side;
      val_r  <= in_value;
    end
    idx_r   <= idx_nxt;
    left_r  <= left_nxt;
    hst_r   <= hst_nxt;
    hdata_r <= hdata_nxt;
    hfidx_r <= hfidx_nxt;
    if (out_load) begin
      out_status_r <= hst_r;
      out_data_r   <= hdata_r;
      out_fidx_r   <= hfidx_r;
      out_count_r  <= total;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data        = out_data_r;
  assign out_found_index = out_fidx_r;
  assign out_count       = out_count_r;

  // The two stacks never hold more than the capacity in use.
  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, low_r} + {1'b0, high_r}) <= {1'b0, cap_eff})
    else $error("stack counts exceed the effective capacity");

  // A scan always has at least one entry left to compare.
  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (left_r != '0))
    else $error("search scan running with no entries left");

  // A held result moves to the output register once the slot is free.
  a_hold_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_HOLD) && out_free) |=> out_valid_r)
    else $error("held result was not shown on the result channel");

  // Items are taken only when no other item is in flight.
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");

endmodule

>>> src/shared_array_dual_stack.sv
// Top level of the shared-array dual stack: capacity register, APB-style port and wiring.
// Instantiates sads_mem and sads_seq; uses sads_pkg.
//
// Two signed stacks share one array of DEPTH entries. Stack A (side 0) grows up from
// index 0, stack B (side 1) grows down from capacity-1. Each input transfer names an
// operation (push, pop, peek, clear, search) and a side, and yields exactly one result
// transfer with status, data, found index and the total element count after it.
// Items are handled one at a time by a small sequencer around one memory port and one
// compare unit. Push, clear and unused codes pass from execution straight to the held
// result; pop and peek add one registered memory read unless the side is empty; and
// search compares entries one per cycle, from the top toward the base, at most the
// side's count (none when the side is empty). A finished result sits in an output
// register while the next item is accepted; if the receiver stalls, the sequencer
// holds one further result and then stops taking items until the output register
// drains.
// Reset empties both stacks and sets the capacity register to DEPTH; entries are not
// cleared. Writing the capacity register (byte address 0) empties both stacks and keeps
// the low $clog2(DEPTH+1) bits; a kept value of 0 acts as 1 and one above DEPTH acts
// as DEPTH, while reads return the kept bits.
module shared_array_dual_stack
  import sads_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [APB_AW-1:0]                 paddr,
  input  logic [APB_DW-1:0]                 pwdata,
  output logic [APB_DW-1:0]                 prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_op,
  input  logic                              in_side,
  input  logic signed [DATA_WIDTH-1:0]      in_value,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [DATA_WIDTH-1:0]      out_data,
  output logic [$clog2(DEPTH)-1:0]          out_found_index,
  output logic [$clog2(DEPTH+1)-1:0]        out_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      cap_eff;
  logic                  cfg_wr;
  logic                  cfg_clear;
  mem_ctl_t              mem_ctl;
  logic [IDX_W-1:0]      mem_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic [DATA_WIDTH-1:0] seq_data;

  // Register write decode: the write lands on the access cycle.
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_wr && (paddr[2] == REG_CAPACITY);
  assign cap_nxt   = cfg_clear ? pwdata[CNT_W-1:0] : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(DEPTH);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // Read back the written bits.
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DW-CNT_W){1'b0}}, cap_r} : '0;

  // Capacity in effect: clamp to the range one to DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  sads_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  sads_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cap_eff         (cap_eff),
    .cfg_clear       (cfg_clear),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_side         (in_side),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data        (seq_data),
    .out_found_index (out_found_index),
    .out_count       (out_count),
    .mem_ctl         (mem_ctl),
    .mem_addr        (mem_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_data     (mem_rd_data)
  );

  assign out_data = $signed(seq_data);

endmodule
